// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("stft assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("stft assertion failed");

`endif

// ----- rtl/stft_pkg.sv -----
// Shared types, constants and trig table for the STFT level analyzer.
`default_nettype none
package stft_pkg;
	localparam int SAMPLE_W = 16;
	localparam int XW_W = 17;
	localparam int TRIG_W = 17;
	localparam int PROD_W = 34;
	localparam int ACC_W = 40;
	localparam int MAG_W = 25;
	localparam int PWR_W = 51;
	localparam int BIN_W = 6;
	localparam int DB_W = 16;
	localparam int ANG_W = 6;

	localparam logic signed [DB_W-1:0] LEVEL_MIN = -16'sd25600;
	localparam logic signed [DB_W-1:0] LEVEL_MAX = 16'sd7680;
	localparam logic [17:0] DB_PER_LOG2 = 18'd197283;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [XW_W-1:0] xw_t;
	typedef logic signed [TRIG_W-1:0] trig_t;
	typedef logic [PWR_W-1:0] pwr_t;

	typedef struct packed {
		logic [BIN_W-1:0] bin;
		pwr_t power;
	} pwr_word_t;

	localparam logic [16:0] QUARTER_SINE [17] = '{
		17'd0, 17'd3212, 17'd6393, 17'd9512, 17'd12540, 17'd15447, 17'd18205,
		17'd20788, 17'd23170, 17'd25330, 17'd27246, 17'd28899, 17'd30274,
		17'd31357, 17'd32138, 17'd32610, 17'd32768
	};

	function automatic trig_t sine64(input logic [ANG_W-1:0] a);
		logic [3:0] r;
		trig_t fwd;
		trig_t rev;
		trig_t res;
		r = a[3:0];
		fwd = trig_t'(QUARTER_SINE[r]);
		rev = trig_t'(QUARTER_SINE[5'(5'd16 - {1'b0, r})]);
		unique case (a[5:4])
			2'd0: res = fwd;
			2'd1: res = rev;
			2'd2: res = -fwd;
			default: res = -rev;
		endcase
		return res;
	endfunction

	function automatic trig_t cosine64(input logic [ANG_W-1:0] a);
		return sine64(ANG_W'(a + 6'd16));
	endfunction
endpackage
`default_nettype wire

// ----- rtl/stft_if.sv -----
// Stream interfaces for the sample input and level output channels.
`default_nettype none
interface stft_sample_if;
	logic valid;
	logic ready;
	logic signed [15:0] sample;
	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface stft_level_if;
	logic valid;
	logic ready;
	logic [5:0] bin_index;
	logic signed [15:0] level_db;
	logic last_bin;
	modport source (output valid, output bin_index, output level_db, output last_bin,
		input ready);
	modport sink (input valid, input bin_index, input level_db, input last_bin,
		output ready);
endinterface
`default_nettype wire

// ----- rtl/stft_fifo.sv -----
// Small word queue between the windowing front and the transform back end.
`default_nettype none
module stft_fifo import stft_pkg::*; #(
	parameter int W = 17,
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [W-1:0] in_data,
	output logic out_valid,
	input logic out_ready,
	output logic [W-1:0] out_data
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic push, pop;

	assign in_ready = cnt_q != CW'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_data = mem_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_q + 1'b1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= CW'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= CW'(cnt_q - 1'b1);
			end
		end
	end
endmodule
`default_nettype wire

// ----- rtl/stft_front.sv -----
// Sample history, hop counting and Hann windowing of each frame.
`default_nettype none
module stft_front import stft_pkg::*; #(
	parameter int FFT_SIZE = 64,
	parameter int HOP_SIZE = 16
) (
	input logic clk,
	input logic arst_n,
	stft_sample_if.sink samples,
	output logic push,
	output xw_t push_data,
	input logic push_ready
);
	localparam int AW = $clog2(FFT_SIZE);
	localparam int HW = $clog2(HOP_SIZE + 1);
	localparam int ASH = ANG_W - AW;

	typedef enum logic {ST_TAKE, ST_READ} state_t;

	state_t state_q;
	logic [AW-1:0] wpos_q, rd_n_q, rd_addr;
	logic [HW-1:0] hop_q;
	logic [FFT_SIZE-1:0] hist_vld_q;
	sample_t hist_mem [FFT_SIZE];

	logic valid_s1, valid_s2, ok_s1;
	sample_t samp_s1;
	logic [16:0] win_s1;
	xw_t xw_s2;

	logic accept, adv, issue;
	logic [ANG_W-1:0] widx;
	logic signed [18:0] wdiff;
	logic [16:0] win;
	sample_t samp_eff;
	logic signed [PROD_W-1:0] prod;
	logic [PROD_W-1:0] mag;
	logic [PROD_W-1:0] rnd;
	xw_t xw;

	assign samples.ready = state_q == ST_TAKE;
	assign accept = samples.valid && samples.ready;
	assign adv = !valid_s2 || push_ready;
	assign issue = (state_q == ST_READ) && adv;
	assign rd_addr = AW'(wpos_q + rd_n_q);
	assign push = valid_s2;
	assign push_data = xw_s2;

	always_comb begin
		widx = ANG_W'(ANG_W'(rd_n_q) << ASH);
		wdiff = 19'sd32768 - 19'(cosine64(widx));
		win = 17'(wdiff >>> 1);
		samp_eff = ok_s1 ? samp_s1 : '0;
		prod = PROD_W'(samp_eff) * PROD_W'($signed({1'b0, win_s1}));
		mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
		rnd = (mag + PROD_W'(16384)) >> 15;
		xw = prod[PROD_W-1] ? -xw_t'(rnd[XW_W-1:0]) : xw_t'(rnd[XW_W-1:0]);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hist_mem[wpos_q] <= samples.sample;
		end
		if (adv) begin
			samp_s1 <= hist_mem[rd_addr];
			ok_s1 <= hist_vld_q[rd_addr];
			win_s1 <= win;
			xw_s2 <= xw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_TAKE;
			wpos_q <= '0;
			rd_n_q <= '0;
			hop_q <= '0;
			hist_vld_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv) begin
				valid_s1 <= issue;
				valid_s2 <= valid_s1;
			end
			unique case (state_q)
				ST_TAKE: begin
					if (accept) begin
						hist_vld_q[wpos_q] <= 1'b1;
						wpos_q <= AW'(wpos_q + 1'b1);
						if (hop_q == HW'(HOP_SIZE - 1)) begin
							hop_q <= '0;
							rd_n_q <= '0;
							state_q <= ST_READ;
						end else begin
							hop_q <= HW'(hop_q + 1'b1);
						end
					end
				end
				ST_READ: begin
					if (adv) begin
						rd_n_q <= AW'(rd_n_q + 1'b1);
						if (rd_n_q == AW'(FFT_SIZE - 1)) begin
							state_q <= ST_TAKE;
						end
					end
				end
				default: state_q <= ST_TAKE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/stft_dft.sv -----
// Frame buffer and per-bin multiply-accumulate DFT producing bin power.
`default_nettype none
module stft_dft import stft_pkg::*; #(
	parameter int FFT_SIZE = 64
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input xw_t in_data,
	output logic out_valid,
	input logic out_ready,
	output pwr_word_t out_word
);
	localparam int AW = $clog2(FFT_SIZE);
	localparam int STEP = 64 / FFT_SIZE;

	typedef enum logic [2:0] {
		ST_LOAD, ST_MAC, ST_DRAIN, ST_ROUND, ST_SQ_RE, ST_SQ_IM, ST_HAND
	} state_t;

	state_t state_q;
	xw_t work_mem [FFT_SIZE];
	logic [AW-1:0] n_q, k_q;
	logic [ANG_W-1:0] kstep_q, phase_q;
	logic mv_s1, mv_s2;
	xw_t xw_s1;
	trig_t cos_s1, sin_s1;
	logic signed [PROD_W-1:0] pc_s2, ps_s2;
	logic signed [ACC_W-1:0] re_q, im_q;
	logic [MAG_W-1:0] rmag_q, imag_q;
	pwr_t sq_q;
	pwr_word_t word_q;
	logic pop;

	function automatic logic [MAG_W-1:0] round_mag(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-1:0] m;
		logic [ACC_W-1:0] r;
		m = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
		r = (m + ACC_W'(16384)) >> 15;
		return r[MAG_W-1:0];
	endfunction

	assign in_ready = state_q == ST_LOAD;
	assign pop = in_valid && in_ready;
	assign out_valid = state_q == ST_HAND;
	assign out_word = word_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			work_mem[n_q] <= in_data;
		end
		xw_s1 <= work_mem[n_q];
		cos_s1 <= cosine64(phase_q);
		sin_s1 <= sine64(phase_q);
		pc_s2 <= PROD_W'(xw_s1) * PROD_W'(cos_s1);
		ps_s2 <= PROD_W'(xw_s1) * PROD_W'(sin_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			n_q <= '0;
			k_q <= '0;
			kstep_q <= '0;
			phase_q <= '0;
			mv_s1 <= 1'b0;
			mv_s2 <= 1'b0;
			re_q <= '0;
			im_q <= '0;
			rmag_q <= '0;
			imag_q <= '0;
			sq_q <= '0;
			word_q <= '0;
		end else begin
			mv_s1 <= state_q == ST_MAC;
			mv_s2 <= mv_s1;
			if (mv_s2) begin
				re_q <= re_q + ACC_W'(pc_s2);
				im_q <= im_q - ACC_W'(ps_s2);
			end
			unique case (state_q)
				ST_LOAD: begin
					if (pop) begin
						if (n_q == AW'(FFT_SIZE - 1)) begin
							n_q <= '0;
							phase_q <= '0;
							re_q <= '0;
							im_q <= '0;
							state_q <= ST_MAC;
						end else begin
							n_q <= AW'(n_q + 1'b1);
						end
					end
				end
				ST_MAC: begin
					n_q <= AW'(n_q + 1'b1);
					phase_q <= ANG_W'(phase_q + kstep_q);
					if (n_q == AW'(FFT_SIZE - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!mv_s1 && !mv_s2) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					rmag_q <= round_mag(re_q);
					imag_q <= round_mag(im_q);
					state_q <= ST_SQ_RE;
				end
				ST_SQ_RE: begin
					sq_q <= PWR_W'(rmag_q) * PWR_W'(rmag_q);
					state_q <= ST_SQ_IM;
				end
				ST_SQ_IM: begin
					word_q.power <= PWR_W'(sq_q + PWR_W'(imag_q) * PWR_W'(imag_q));
					word_q.bin <= BIN_W'(k_q);
					state_q <= ST_HAND;
				end
				ST_HAND: begin
					if (out_ready) begin
						n_q <= '0;
						phase_q <= '0;
						re_q <= '0;
						im_q <= '0;
						if (k_q == AW'(FFT_SIZE / 2)) begin
							k_q <= '0;
							kstep_q <= '0;
							state_q <= ST_LOAD;
						end else begin
							k_q <= AW'(k_q + 1'b1);
							kstep_q <= ANG_W'(kstep_q + ANG_W'(STEP));
							state_q <= ST_MAC;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/stft_log.sv -----
// Iterative log2 of bin power and conversion to Q8.8 dB with output register.
`default_nettype none
module stft_log import stft_pkg::*; #(
	parameter int FFT_SIZE = 64
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input pwr_word_t in_word,
	stft_level_if.source levels
);
	localparam int AW = $clog2(FFT_SIZE);
	localparam int EW = $clog2(PWR_W);
	localparam int OFFSET = (29 + 2 * AW) * 65536;
	localparam int DBP_W = 43;

	typedef enum logic [2:0] {ST_IDLE, ST_NORM, ST_SQR, ST_SCALE, ST_DB, ST_OUT} state_t;

	state_t state_q;
	pwr_t m_q;
	logic [EW-1:0] e_q;
	logic [30:0] mant_q;
	logic [3:0] i_q;
	logic [15:0] frac_q;
	logic [BIN_W-1:0] bin_q;
	logic signed [DBP_W-1:0] prod_q;
	logic signed [DB_W-1:0] db_q;

	logic [61:0] sqf;
	logic [31:0] t;
	logic signed [23:0] v;
	logic signed [DBP_W-1:0] dbq;

	assign in_ready = state_q == ST_IDLE;
	assign levels.valid = state_q == ST_OUT;
	assign levels.bin_index = bin_q;
	assign levels.level_db = db_q;
	assign levels.last_bin = bin_q == BIN_W'(FFT_SIZE / 2);

	always_comb begin
		sqf = 62'(mant_q) * 62'(mant_q);
		t = sqf[61:30];
		v = 24'({2'b00, e_q, frac_q}) - 24'(OFFSET);
		dbq = (prod_q + DBP_W'(64'sd8388608)) >>> 24;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_q <= '0;
			e_q <= '0;
			mant_q <= '0;
			i_q <= '0;
			frac_q <= '0;
			bin_q <= '0;
			prod_q <= '0;
			db_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						bin_q <= in_word.bin;
						m_q <= in_word.power;
						e_q <= EW'(PWR_W - 1);
						if (in_word.power == '0) begin
							db_q <= LEVEL_MIN;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_NORM;
						end
					end
				end
				ST_NORM: begin
					if (m_q[PWR_W-1]) begin
						mant_q <= m_q[PWR_W-1 -: 31];
						i_q <= 4'd15;
						frac_q <= '0;
						state_q <= ST_SQR;
					end else begin
						m_q <= PWR_W'(m_q << 1);
						e_q <= EW'(e_q - 1'b1);
					end
				end
				ST_SQR: begin
					if (t[31]) begin
						mant_q <= t[31:1];
						frac_q[i_q] <= 1'b1;
					end else begin
						mant_q <= t[30:0];
					end
					if (i_q == 4'd0) begin
						state_q <= ST_SCALE;
					end else begin
						i_q <= 4'(i_q - 1'b1);
					end
				end
				ST_SCALE: begin
					prod_q <= DBP_W'(v) * DBP_W'($signed({1'b0, DB_PER_LOG2}));
					state_q <= ST_DB;
				end
				ST_DB: begin
					priority if (dbq < DBP_W'(LEVEL_MIN)) begin
						db_q <= LEVEL_MIN;
					end else if (dbq > DBP_W'(LEVEL_MAX)) begin
						db_q <= LEVEL_MAX;
					end else begin
						db_q <= dbq[DB_W-1:0];
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (levels.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/stft_spectrum_analyzer_db.sv -----
// The log2 unit's run time per bin depends on how far the bin power must be normalized.
// Each bin runs the MAC taps, drain, round, two squares and handoff; a frame is loaded,
// then its 33 bins follow, and no new frame is loaded until its last bin is handed off.
// Input stalls while the front reads out each frame, longer until the DFT finishes its frame.
// Reset (async, active low) clears history, write position, hop count and all control.
`default_nettype none
module stft_spectrum_analyzer_db import stft_pkg::*; #(
	parameter int FFT_SIZE = 64,
	parameter int HOP_SIZE = 16
) (
	input logic clk,
	input logic arst_n,
	stft_sample_if.sink samples,
	stft_level_if.source levels
);
	logic f_valid, f_ready, q_valid, q_ready, p_valid, p_ready;
	xw_t f_data, q_data;
	pwr_word_t p_word;

	stft_front #(.FFT_SIZE(FFT_SIZE), .HOP_SIZE(HOP_SIZE)) u_front (
		.clk(clk), .arst_n(arst_n), .samples(samples),
		.push(f_valid), .push_data(f_data), .push_ready(f_ready)
	);

	stft_fifo #(.W(XW_W), .DEPTH(4)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
		.out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
	);

	stft_dft #(.FFT_SIZE(FFT_SIZE)) u_dft (
		.clk(clk), .arst_n(arst_n),
		.in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
		.out_valid(p_valid), .out_ready(p_ready), .out_word(p_word)
	);

	stft_log #(.FFT_SIZE(FFT_SIZE)) u_log (
		.clk(clk), .arst_n(arst_n),
		.in_valid(p_valid), .in_ready(p_ready), .in_word(p_word),
		.levels(levels)
	);
endmodule
`default_nettype wire

// ----- rtl/stft_checker.sv -----
// Port-level checks on the level output channel, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module stft_checker #(
	parameter int FFT_SIZE = 64
) (
	input logic clk,
	input logic arst_n,
	input logic valid,
	input logic ready,
	input logic [5:0] bin_index,
	input logic signed [15:0] level_db,
	input logic last_bin
);
	`ASSERT_IMPL(a_bin_range, clk, arst_n, valid, bin_index <= 6'(FFT_SIZE / 2))
	`ASSERT_IMPL(a_last_flag, clk, arst_n, valid, last_bin == (bin_index == 6'(FFT_SIZE / 2)))
	`ASSERT_IMPL(a_db_range, clk, arst_n, valid, (level_db >= -16'sd25600) && (level_db <= 16'sd7680))
	`ASSERT_NEXT(a_hold, clk, arst_n, valid && !ready, valid && $stable(bin_index) && $stable(level_db))
endmodule

bind stft_spectrum_analyzer_db stft_checker #(.FFT_SIZE(FFT_SIZE)) u_stft_checker (
	.clk(clk), .arst_n(arst_n), .valid(levels.valid), .ready(levels.ready),
	.bin_index(levels.bin_index), .level_db(levels.level_db), .last_bin(levels.last_bin)
);
`default_nettype wire

// ----- tb/sv/stft_spectrum_analyzer_db_tb.sv -----
// Testbench for the STFT dB spectrum analyzer: directed and random samples vs a predictor.
module stft_spectrum_analyzer_db_tb;
	import stft_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N = 64;
	localparam int HOP = 16;
	localparam int NBINS = N / 2 + 1;
	localparam int IDLE_LIMIT = 5000;

	typedef struct {
		logic [5:0] bin_index;
		logic signed [15:0] level_db;
		logic last_bin;
	} level_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	stft_sample_if samples ();
	stft_level_if levels ();

	stft_spectrum_analyzer_db #(.FFT_SIZE(N), .HOP_SIZE(HOP)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples.sink),
		.levels(levels.source)
	);

	always #5 clk = ~clk;

	level_word_t expected_levels[$];
	logic signed [15:0] history[N];
	int wr_pos;
	int hop_cnt;
	int mismatches = 0;
	int idle_cycles = 0;
	int out_wait = 0;
	bit stall_enable = 1;

	initial begin
		samples.valid = 1'b0;
		samples.sample = '0;
		levels.ready = 1'b0;
	end

	function automatic longint rnd15(longint v);
		longint mag;
		mag = (v < 0) ? -v : v;
		mag = (mag + 16384) >>> 15;
		return (v < 0) ? -mag : mag;
	endfunction

	function automatic longint log2q16(longint unsigned v);
		int e;
		longint unsigned m;
		longint unsigned frac;
		e = 63;
		frac = 0;
		while (e > 0 && v[e] == 1'b0)
			e--;
		m = (e >= 30) ? (v >> (e - 30)) : (v << (30 - e));
		for (int i = 15; i >= 0; i--) begin
			m = (m * m) >> 30;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				frac |= 64'd1 << i;
			end
		end
		return (longint'(e) << 16) | longint'(frac);
	endfunction

	function automatic logic signed [15:0] power_level(longint unsigned p);
		longint v;
		longint db;
		if (p == 0)
			return LEVEL_MIN;
		v = log2q16(p) - (longint'(29) << 16) - 2 * log2q16(N);
		db = (v * 197283 + (longint'(1) << 23)) >>> 24;
		if (db < -25600)
			db = -25600;
		if (db > 7680)
			db = 7680;
		return 16'(db);
	endfunction

	function automatic longint trig_sin(int a);
		return longint'(sine64(6'(a)));
	endfunction

	task automatic predict_spectrum(logic signed [15:0] s);
		longint xw[N];
		longint re, im, rq, iq, w;
		int a;
		level_word_t lw;
		history[wr_pos] = s;
		wr_pos = (wr_pos + 1) % N;
		hop_cnt++;
		if (hop_cnt < HOP)
			return;
		hop_cnt = 0;
		for (int n = 0; n < N; n++) begin
			a = (n * 64 / N) & 63;
			w = (32768 - trig_sin((a + 16) & 63)) >>> 1;
			xw[n] = rnd15(longint'(history[(wr_pos + n) % N]) * w);
		end
		for (int k = 0; k < NBINS; k++) begin
			re = 0;
			im = 0;
			for (int n = 0; n < N; n++) begin
				a = ((k * n * 64) / N) & 63;
				re += xw[n] * trig_sin((a + 16) & 63);
				im -= xw[n] * trig_sin(a);
			end
			rq = rnd15(re);
			iq = rnd15(im);
			lw.bin_index = 6'(k);
			lw.level_db = power_level(longint'(rq * rq + iq * iq));
			lw.last_bin = (k == NBINS - 1);
			expected_levels.push_back(lw);
		end
	endtask

	task automatic send_sample(logic signed [15:0] s);
		int gap;
		gap = stall_enable ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			samples.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.sample <= s;
		do @(posedge clk); while (!samples.ready);
		predict_spectrum(s);
	endtask

	// output side: per-word ready delay, compare against oldest expectation
	always @(posedge clk) begin
		level_word_t e;
		if (arst_n) begin
			if (levels.valid && levels.ready) begin
				if (expected_levels.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected level word bin=%0d db=%0d", levels.bin_index,
							levels.level_db);
				end else begin
					e = expected_levels.pop_front();
					if (levels.bin_index !== e.bin_index || levels.level_db !== e.level_db
							|| levels.last_bin !== e.last_bin) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch exp bin=%0d db=%0d last=%0b got bin=%0d db=%0d last=%0b",
								e.bin_index, e.level_db, e.last_bin, levels.bin_index,
								levels.level_db, levels.last_bin);
					end
				end
				out_wait = stall_enable ? $urandom_range(0, 11) : 0;
			end else if (levels.valid && out_wait > 0) begin
				out_wait--;
			end
			levels.ready <= (out_wait == 0);
		end
	end

	always @(posedge clk) begin
		if ((samples.valid && samples.ready) || (levels.valid && levels.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("[stft_spectrum_analyzer_db] ERROR");
			$finish;
		end
	end

	task automatic wait_drained();
		samples.valid <= 1'b0;
		@(posedge clk);
		while (expected_levels.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_extremes();
		repeat (HOP) send_sample(16'sh7fff);
		repeat (HOP) send_sample(-16'sh8000);
		for (int i = 0; i < 16; i++)
			send_sample((i % 2) ? 16'sh7fff : -16'sh8000);
	endtask

	task automatic test_silence();
		// zero power floor once history is flushed
		repeat (N + HOP) send_sample(16'sh0000);
		send_sample(16'sh0001);
		repeat (HOP - 1) send_sample(16'sh0000);
	endtask

	task automatic test_drain_pause();
		wait_drained();
		repeat (HOP) send_sample(16'(($urandom_range(0, 1)) ? 16'sh4000 : -16'sh4000));
	endtask

	task automatic test_random();
		logic signed [15:0] s;
		for (int i = 0; i < 220; i++) begin
			case ($urandom_range(0, 3))
				0: s = 16'($urandom);
				1: s = 16'($signed(16'($urandom_range(0, 255))) - 128);
				2: s = 16'(int'(16000.0 * $sin(6.2832 * i * $urandom_range(1, 31) / 64.0)));
				default: s = ($urandom_range(0, 1)) ? 16'sh7fff : -16'sh8000;
			endcase
			if (i >= 150 && i < 200)
				stall_enable = 0;
			else
				stall_enable = 1;
			send_sample(s);
		end
	endtask

	initial begin
		wr_pos = 0;
		hop_cnt = 0;
		for (int i = 0; i < N; i++)
			history[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_silence();
		test_drain_pause();
		test_random();
		wait_drained();
		repeat (300) @(posedge clk);
		if (mismatches == 0 && expected_levels.size() == 0)
			$display("[stft_spectrum_analyzer_db] OK");
		else
			$display("[stft_spectrum_analyzer_db] ERROR");
		$finish;
	end
endmodule
